// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// rmq_pkg: widths, stage map and shared types of the rotation matrix to quaternion unit
// no dependencies

package rmq_pkg;

  // fixed point format of elements and results
  localparam int FRAC_BITS = 15;
  localparam int DW        = 16;

  // unnormalized component width (signed, values lie in -2.0 .. +4.0)
  localparam int CW    = FRAC_BITS + 4;
  // squares and their sum
  localparam int SQ_W  = 2 * CW;
  // magnitude (floor square root of the sum)
  localparam int RT_W  = SQ_W / 2;
  // scaled dividend |c| * 2^FRAC_BITS + mag / 2
  localparam int NUM_W = RT_W + FRAC_BITS;

  localparam logic signed [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE_Q   = CW'(1) << FRAC_BITS;

  // component lanes
  localparam int LN_X = 0;
  localparam int LN_Y = 1;
  localparam int LN_Z = 2;
  localparam int LN_W = 3;

  // pipeline stage map
  localparam int S_COMP = 0;
  localparam int S_SQ   = 1;
  localparam int S_SUM  = 2;
  localparam int S_RT0  = 3;
  localparam int S_PREP = S_RT0 + RT_W;
  localparam int S_DIV0 = S_PREP + 1;
  localparam int S_OUT  = S_DIV0 + FRAC_BITS;
  localparam int NST    = S_OUT + 1;

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t [3:0] quad_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [FRAC_BITS-1:0] q;
    logic [RT_W-1:0]      rem;
    logic [FRAC_BITS-1:0] low;
    logic                 neg;
    logic                 sat;
  } div_lane_t;

  typedef struct packed {
    logic [RT_W-1:0]  mag;
    logic             deg;
    div_lane_t [3:0]  lane;
  } div_word_t;

endpackage

// ----- rtl/rmq_if.sv -----
`timescale 1ns / 1ps
// rmq_in_if / rmq_out_if: valid-ready channels of the quaternion unit
// depends on rmq_pkg

interface rmq_in_if import rmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] elem_0_0;
  logic signed [DW-1:0] elem_0_1;
  logic signed [DW-1:0] elem_0_2;
  logic signed [DW-1:0] elem_1_0;
  logic signed [DW-1:0] elem_1_1;
  logic signed [DW-1:0] elem_1_2;
  logic signed [DW-1:0] elem_2_0;
  logic signed [DW-1:0] elem_2_1;
  logic signed [DW-1:0] elem_2_2;

  modport source (
    output valid, elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2,
           elem_2_0, elem_2_1, elem_2_2,
    input  ready
  );
  modport sink (
    input  valid, elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2,
           elem_2_0, elem_2_1, elem_2_2,
    output ready
  );
endinterface

interface rmq_out_if import rmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] quat_x;
  logic signed [DW-1:0] quat_y;
  logic signed [DW-1:0] quat_z;
  logic signed [DW-1:0] quat_w;
  logic                 degenerate;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
    input  ready
  );
  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, degenerate,
    output ready
  );
endinterface

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
`timescale 1ns / 1ps
// rotation_matrix_to_quaternion_unit: top level of the matrix to quaternion pipeline
// depends on rmq_pkg, rmq_if (rmq_in_if, rmq_out_if) and rmq_div_pipe
//
// Usage
//   in_ch  : one beat carries the nine Q1.15 elements of a 3x3 rotation matrix.
//   out_ch : one beat carries the normalized quaternion (x, y, z, w) in Q1.15,
//            saturated, plus degenerate when the magnitude came out zero
//            (all four components are then zero).
//   Both channels move a beat when valid and ready are high at a clock edge.
// Throughput and stages
//   One matrix per cycle while out_ch does not stall. A result passes 3 stages
//   for branch select, squares and sum, 19 for the square root (one root bit
//   per stage), 1 to scale the dividends, 15 for the divider (one quotient bit
//   per stage) and 1 for saturation into the output register.
// Reset and stalls
//   rst_n is synchronous, active low, and empties the pipeline. Each stage
//   holds when it is full and the stage after it cannot take its beat, so a
//   stalled receiver backs the pipeline up bubble by bubble; in_ch.ready
//   stays high as long as the first stage is free or moving.

module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rmq_in_if.sink       in_ch,
  rmq_out_if.source    out_ch
);

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  // stage advance chain, from the output back to the input
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[S_COMP];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_ch.valid : v_r[k-1 < 0 ? 0 : k-1];
        end
      end
    end
  end

  // branch select and unnormalized components
  comp_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  quad_t c_nxt, c0_r, c1_r, c2_r;
  logic  sel_x, sel_y;

  always_comb begin
    m00 = CW'(in_ch.elem_0_0);
    m01 = CW'(in_ch.elem_0_1);
    m02 = CW'(in_ch.elem_0_2);
    m10 = CW'(in_ch.elem_1_0);
    m11 = CW'(in_ch.elem_1_1);
    m12 = CW'(in_ch.elem_1_2);
    m20 = CW'(in_ch.elem_2_0);
    m21 = CW'(in_ch.elem_2_1);
    m22 = CW'(in_ch.elem_2_2);
    sel_x = (m00 > m11) && (m00 > m22);
    sel_y = !sel_x && (m11 > m00) && (m11 > m22);
    if (sel_x) begin
      c_nxt[LN_X] = m00 - m11 - m22 + ONE_Q;
      c_nxt[LN_Y] = m10 + m01;
      c_nxt[LN_Z] = m20 + m02;
      c_nxt[LN_W] = m12 - m21;
    end else if (sel_y) begin
      c_nxt[LN_Y] = m11 - m00 - m22 + ONE_Q;
      c_nxt[LN_X] = m10 + m01;
      c_nxt[LN_Z] = m21 + m12;
      c_nxt[LN_W] = m20 - m02;
    end else begin
      c_nxt[LN_Z] = m22 - m00 - m11 + ONE_Q;
      c_nxt[LN_X] = m20 + m02;
      c_nxt[LN_Y] = m12 + m21;
      c_nxt[LN_W] = m01 - m10;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_COMP]) begin
      c0_r <= c_nxt;
    end
  end

  // squares
  logic [SQ_W-1:0] sq_r [4];

  always_ff @(posedge clk) begin
    if (en[S_SQ]) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= SQ_W'($signed(c0_r[i]) * $signed(c0_r[i]));
      end
      c1_r <= c0_r;
    end
  end

  // sum of squares
  logic [SQ_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      sum_r <= (sq_r[0] + sq_r[1]) + (sq_r[2] + sq_r[3]);
      c2_r  <= c1_r;
    end
  end

  // floor square root, one root bit per stage
  logic [SQ_W-1:0] rad_r  [RT_W];
  logic [RT_W:0]   rem_r  [RT_W];
  logic [RT_W-1:0] root_r [RT_W];
  quad_t           cs_r   [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_rt
    logic [SQ_W-1:0] src_rad;
    logic [RT_W:0]   src_rem;
    logic [RT_W-1:0] src_root;
    quad_t           src_c;
    logic [RT_W+2:0] remx;
    logic [RT_W+2:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign src_rad  = sum_r;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_c    = c2_r;
    end else begin : g_next
      assign src_rad  = rad_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_c    = cs_r[k-1];
    end

    assign remx  = {src_rem, src_rad[SQ_W-1 -: 2]};
    assign trial = (RT_W + 3)'({src_root, 2'b01});
    assign ge    = remx >= trial;

    always_ff @(posedge clk) begin
      if (en[S_RT0 + k]) begin
        rad_r[k]  <= src_rad << 2;
        rem_r[k]  <= ge ? (RT_W + 1)'(remx - trial) : (RT_W + 1)'(remx);
        root_r[k] <= {src_root[RT_W-2:0], ge};
        cs_r[k]   <= src_c;
      end
    end
  end

  // rounded dividends and saturation test
  div_word_t prep_nxt, prep_r, div_o;
  logic [RT_W-1:0] mag;

  assign mag = root_r[RT_W-1];

  always_comb begin
    logic [CW-1:0]    a;
    logic [NUM_W-1:0] num;
    prep_nxt.mag = mag;
    prep_nxt.deg = (mag == '0);
    for (int i = 0; i < 4; i++) begin
      a   = cs_r[RT_W-1][i][CW-1] ? CW'(-cs_r[RT_W-1][i]) : CW'(cs_r[RT_W-1][i]);
      num = (NUM_W'(a) << FRAC_BITS) + NUM_W'(mag >> 1);
      prep_nxt.lane[i].q   = '0;
      prep_nxt.lane[i].rem = num[NUM_W-1 -: RT_W];
      prep_nxt.lane[i].low = num[FRAC_BITS-1:0];
      prep_nxt.lane[i].neg = cs_r[RT_W-1][i][CW-1];
      prep_nxt.lane[i].sat = num >= (NUM_W'(mag) << FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PREP]) begin
      prep_r <= prep_nxt;
    end
  end

  rmq_div_pipe u_div (
    .clk   (clk),
    .en    (en[S_DIV0 +: FRAC_BITS]),
    .div_i (prep_r),
    .div_o (div_o)
  );

  // sign, saturation and degenerate case into the output register
  logic signed [DW-1:0] q_nxt [4];
  logic signed [DW-1:0] q_r   [4];
  logic                 deg_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (div_o.deg) begin
        q_nxt[i] = '0;
      end else if (div_o.lane[i].neg) begin
        q_nxt[i] = div_o.lane[i].sat ? OUT_MIN : -$signed({1'b0, div_o.lane[i].q});
      end else begin
        q_nxt[i] = div_o.lane[i].sat ? OUT_MAX : $signed({1'b0, div_o.lane[i].q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      q_r   <= q_nxt;
      deg_r <= div_o.deg;
    end
  end

  assign out_ch.valid      = v_r[S_OUT];
  assign out_ch.quat_x     = q_r[LN_X];
  assign out_ch.quat_y     = q_r[LN_Y];
  assign out_ch.quat_z     = q_r[LN_Z];
  assign out_ch.quat_w     = q_r[LN_W];
  assign out_ch.degenerate = deg_r;

endmodule

// ----- rtl/rmq_div_pipe.sv -----
`timescale 1ns / 1ps
// rmq_div_pipe: four-lane restoring divider, one quotient bit per stage
// depends on rmq_pkg; stage enables come from the top level valid chain

module rmq_div_pipe import rmq_pkg::*; (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] en,
  input  div_word_t            div_i,
  output div_word_t            div_o
);

  div_word_t st_r [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    div_word_t src;
    div_word_t st_nxt;

    if (k == 0) begin : g_first
      assign src = div_i;
    end else begin : g_next
      assign src = st_r[k-1];
    end

    // shift in one dividend bit per lane, subtract the divisor where it fits
    always_comb begin
      logic [RT_W:0] remx;
      logic          ge;
      st_nxt = src;
      for (int i = 0; i < 4; i++) begin
        remx = {src.lane[i].rem, src.lane[i].low[FRAC_BITS-1]};
        ge   = remx >= {1'b0, src.mag};
        st_nxt.lane[i].rem = ge ? RT_W'(remx - {1'b0, src.mag}) : RT_W'(remx);
        st_nxt.lane[i].q   = {src.lane[i].q[FRAC_BITS-2:0], ge};
        st_nxt.lane[i].low = src.lane[i].low << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign div_o = st_r[FRAC_BITS-1];

endmodule

// ----- rtl/rmq_checker.sv -----
`timescale 1ns / 1ps
// rmq_checker: port-level assertions on the quaternion unit output channel
// depends on rmq_pkg; bound to rotation_matrix_to_quaternion_unit below

module rmq_checker import rmq_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] quat_x,
  input logic signed [DW-1:0] quat_y,
  input logic signed [DW-1:0] quat_z,
  input logic signed [DW-1:0] quat_w,
  input logic                 degenerate
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a zero magnitude gives an all-zero quaternion
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && degenerate) |->
      (quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0))
    else $error("degenerate beat with nonzero component");

  // a nonzero magnitude leaves at least one component nonzero
  a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !degenerate) |->
      (quat_x != '0 || quat_y != '0 || quat_z != '0 || quat_w != '0))
    else $error("normal beat with all components zero");

  // a stalled result beat stays until taken (valid, quat_x and degenerate are checked)
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(quat_x) && $stable(degenerate)))
    else $error("stalled result beat dropped or changed");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .quat_x     (out_ch.quat_x),
  .quat_y     (out_ch.quat_y),
  .quat_z     (out_ch.quat_z),
  .quat_w     (out_ch.quat_w),
  .degenerate (out_ch.degenerate)
);

// ----- test/tb_rotation_matrix_to_quaternion_unit.sv -----
`timescale 1ns / 1ps
// tb_rotation_matrix_to_quaternion_unit: checks the matrix to quaternion pipeline beat by beat
// against a behavioral predictor of branch select, integer root and rounded divide
// depends on rmq_pkg, rmq_if and the rotation_matrix_to_quaternion_unit rtl

module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct {
    elem_t m[9];
  } matrix_t;
  typedef struct {
    elem_t x, y, z, w;
    logic  deg;
  } quat_t;

  localparam int N_RANDOM = 1230;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      mismatch_count = 0;
  int      unexpected_count = 0;
  int      checked_count = 0;
  int      degenerate_seen = 0;
  int      sent_count = 0;
  bit      calm_mode = 0;     // no random idling on either side
  bit      hold_off = 0;      // long receiver hold-off
  bit      in_taken = 0;      // input beat taken at the last rising edge
  bit      stimulus_done = 0;

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // floor square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // rounded divide by magnitude, saturated to the output range
  function automatic elem_t scale_component(longint c, longint unsigned mag);
    longint unsigned a, q;
    a = (c < 0) ? -c : c;
    q = ((a << FRAC_BITS) + mag / 2) / mag;
    if (c < 0) return (q > 32768) ? OUT_MIN : elem_t'(-longint'(q));
    return (q > 32767) ? OUT_MAX : elem_t'(q);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mt);
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, one;
    longint qx, qy, qz, qw;
    longint unsigned mag;
    quat_t r;
    m00 = mt.m[0]; m01 = mt.m[1]; m02 = mt.m[2];
    m10 = mt.m[3]; m11 = mt.m[4]; m12 = mt.m[5];
    m20 = mt.m[6]; m21 = mt.m[7]; m22 = mt.m[8];
    one = longint'(1) << FRAC_BITS;
    // branch on the largest diagonal element, ties for the largest fall to the z branch
    if (m00 > m11 && m00 > m22) begin
      qx = m00 - m11 - m22 + one; qy = m10 + m01; qz = m20 + m02; qw = m12 - m21;
    end else if (m11 > m00 && m11 > m22) begin
      qy = m11 - m00 - m22 + one; qx = m10 + m01; qz = m21 + m12; qw = m20 - m02;
    end else begin
      qz = m22 - m00 - m11 + one; qx = m20 + m02; qy = m12 + m21; qw = m01 - m10;
    end
    mag = int_sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
    if (mag == 0) begin
      r = '{x: 0, y: 0, z: 0, w: 0, deg: 1'b1};
    end else begin
      r.x = scale_component(qx, mag);
      r.y = scale_component(qy, mag);
      r.z = scale_component(qz, mag);
      r.w = scale_component(qw, mag);
      r.deg = 1'b0;
    end
    return r;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mt;
    for (int i = 0; i < 9; i++) mt.m[i] = elem_t'($urandom);
    return mt;
  endfunction

  // rotation-like matrix: any diagonal value, off-diagonal within +-20000
  function automatic matrix_t rand_rotation();
    matrix_t mt;
    for (int i = 0; i < 9; i++) begin
      if (i % 4 == 0) mt.m[i] = elem_t'($urandom_range(0, 65535));
      else mt.m[i] = elem_t'(int'($urandom_range(0, 40000)) - 20000);
    end
    return mt;
  endfunction

  function automatic matrix_t diag_matrix(elem_t a, elem_t b, elem_t c);
    matrix_t mt;
    foreach (mt.m[i]) mt.m[i] = 0;
    mt.m[0] = a; mt.m[4] = b; mt.m[8] = c;
    return mt;
  endfunction

  // driver: offers the next pending matrix, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_mats.size() > 0 && (calm_mode || $urandom_range(0, 99) >= 27)) begin
        in_ch.valid <= 1'b1;
        in_ch.elem_0_0 <= pending_mats[0].m[0];
        in_ch.elem_0_1 <= pending_mats[0].m[1];
        in_ch.elem_0_2 <= pending_mats[0].m[2];
        in_ch.elem_1_0 <= pending_mats[0].m[3];
        in_ch.elem_1_1 <= pending_mats[0].m[4];
        in_ch.elem_1_2 <= pending_mats[0].m[5];
        in_ch.elem_2_0 <= pending_mats[0].m[6];
        in_ch.elem_2_1 <= pending_mats[0].m[7];
        in_ch.elem_2_2 <= pending_mats[0].m[8];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted input beats feed the predictor
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      matrix_t mt;
      mt.m[0] = in_ch.elem_0_0; mt.m[1] = in_ch.elem_0_1; mt.m[2] = in_ch.elem_0_2;
      mt.m[3] = in_ch.elem_1_0; mt.m[4] = in_ch.elem_1_1; mt.m[5] = in_ch.elem_1_2;
      mt.m[6] = in_ch.elem_2_0; mt.m[7] = in_ch.elem_2_1; mt.m[8] = in_ch.elem_2_2;
      expected_quats.push_back(matrix_to_quat(mt));
      void'(pending_mats.pop_front());
      sent_count++;
    end
  end

  // receiver ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm_mode || ($urandom_range(0, 99) >= 27);
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      quat_t exp_q;
      if (expected_quats.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= 10)
          $display("unexpected result beat x=%0d y=%0d z=%0d w=%0d deg=%0b",
                   out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w,
                   out_ch.degenerate);
      end else begin
        exp_q = expected_quats.pop_front();
        checked_count++;
        if (exp_q.deg) degenerate_seen++;
        if (out_ch.quat_x !== exp_q.x || out_ch.quat_y !== exp_q.y ||
            out_ch.quat_z !== exp_q.z || out_ch.quat_w !== exp_q.w ||
            out_ch.degenerate !== exp_q.deg) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display({"mismatch: exp x=%0d y=%0d z=%0d w=%0d deg=%0b, ",
                      "got x=%0d y=%0d z=%0d w=%0d deg=%0b"},
                     exp_q.x, exp_q.y, exp_q.z, exp_q.w, exp_q.deg,
                     out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w,
                     out_ch.degenerate);
        end
      end
    end
  end

  task automatic wait_pending_sent();
    while (pending_mats.size() > 0) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_quats.size() > 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    matrix_t mt;
    in_ch.valid = 1'b0;
    in_ch.elem_0_0 = 0; in_ch.elem_0_1 = 0; in_ch.elem_0_2 = 0;
    in_ch.elem_1_0 = 0; in_ch.elem_1_1 = 0; in_ch.elem_1_2 = 0;
    in_ch.elem_2_0 = 0; in_ch.elem_2_1 = 0; in_ch.elem_2_2 = 0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: identity, each branch, ties, degenerate, extremes, saturation
    pending_mats.push_back(diag_matrix(OUT_MAX, OUT_MAX, OUT_MAX));
    pending_mats.push_back(diag_matrix(OUT_MAX, OUT_MIN, OUT_MIN));
    pending_mats.push_back(diag_matrix(OUT_MIN, OUT_MAX, OUT_MIN));
    pending_mats.push_back(diag_matrix(OUT_MIN, OUT_MIN, OUT_MAX));
    pending_mats.push_back(diag_matrix(100, 100, 50));     // x/y tie goes to z branch
    pending_mats.push_back(diag_matrix(100, 50, 100));     // x/z tie
    pending_mats.push_back(diag_matrix(50, 100, 100));     // y/z tie
    pending_mats.push_back(diag_matrix(0, 0, OUT_MIN));    // zero magnitude
    pending_mats.push_back(diag_matrix(16384, 16384, -32768)); // x/y tie goes to z branch, nonzero magnitude
    pending_mats.push_back(diag_matrix(0, 0, 0));
    mt = diag_matrix(OUT_MIN, OUT_MIN, OUT_MIN);
    pending_mats.push_back(mt);
    foreach (mt.m[i]) mt.m[i] = OUT_MAX;
    pending_mats.push_back(mt);
    foreach (mt.m[i]) mt.m[i] = OUT_MIN;
    pending_mats.push_back(mt);
    foreach (mt.m[i]) mt.m[i] = (i % 2) ? OUT_MAX : OUT_MIN;
    pending_mats.push_back(mt);
    foreach (mt.m[i]) mt.m[i] = (i % 2) ? OUT_MIN : OUT_MAX;
    pending_mats.push_back(mt);
    foreach (mt.m[i]) mt.m[i] = elem_t'(16'h5555);
    pending_mats.push_back(mt);
    foreach (mt.m[i]) mt.m[i] = elem_t'(16'hAAAA);
    pending_mats.push_back(mt);
    // 90 degree turn about z
    mt = diag_matrix(0, 0, OUT_MAX);
    mt.m[1] = OUT_MIN; mt.m[3] = OUT_MAX;
    pending_mats.push_back(mt);
    for (int i = 0; i < 4; i++) pending_mats.push_back(rand_matrix());

    // sender pause until everything is back
    wait_pending_sent();
    wait_results_drained();

    // long stretch without idling, then a long receiver hold-off under load
    calm_mode = 1;
    for (int i = 0; i < 150; i++) pending_mats.push_back(rand_rotation());
    wait_pending_sent();
    calm_mode = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 120; i++) pending_mats.push_back(rand_matrix());
    wait_pending_sent();
    wait_results_drained();

    // random mix: mostly rotation-like, some raw noise and some with a fixed tied diagonal
    for (int i = 0; i < N_RANDOM - 270; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pending_mats.push_back(rand_matrix());
        3: begin
          mt = rand_matrix();
          mt.m[0] = 16384; mt.m[4] = 16384; mt.m[8] = -32768;
          pending_mats.push_back(mt);
        end
        default: pending_mats.push_back(rand_rotation());
      endcase
    end
    wait_pending_sent();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d quaternion beats from %0d matrices, %0d of them degenerate",
             checked_count, sent_count, degenerate_seen);
    $display("covered all branches, ties, saturation, stalls and a long receiver hold-off");
    if (mismatch_count == 0 && unexpected_count == 0 && expected_quats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000 * 20);
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_div_pipe.sv
rtl/rotation_matrix_to_quaternion_unit.sv
rtl/rmq_checker.sv
test/tb_rotation_matrix_to_quaternion_unit.sv
